@@ src/pgmst_pkg.sv @@
package pgmst_pkg;

  localparam int W_W    = 34;  // edge weight width
  localparam int TOT_W  = 41;  // total cost width
  localparam int IDX_W  = 7;   // city index width on the result

  localparam logic KIND_STATION = 1'b0;
  localparam logic KIND_WIRE    = 1'b1;

  typedef struct packed {
    logic [15:0] city_x;
    logic [15:0] city_y;
    logic [31:0] station_cost;
    logic [15:0] wire_rate;
    logic        last_city;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] city_a;
    logic [IDX_W-1:0] city_b;
    logic [TOT_W-1:0] total_cost;
    logic             last;
    logic             overflowed;
  } result_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] cost;
    logic [15:0] rate;
  } city_rec_t;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_IWAIT,
    S_ST_RD, S_ST_WR,
    S_PI_RD, S_PI_LAT, S_PJ_RD, S_PJ_DIFF, S_PJ_MUL,
    S_SORT_GO, S_SORT,
    S_SC_RD, S_SC_FIND, S_SC_WAIT, S_SC_MWAIT,
    S_OUT_RD, S_OUT_EMIT
  } state_t;

  typedef enum logic [2:0] {
    SS_IDLE, SS_PASS, SS_BLK, SS_RD, SS_CMP
  } sort_state_t;

  typedef enum logic [1:0] {
    U_IDLE, U_INIT, U_FIND, U_MERGE
  } uf_state_t;

  typedef enum logic [1:0] {
    UF_NOP, UF_INIT, UF_FIND, UF_MERGE
  } uf_op_t;

endpackage

@@ src/pgmst_sort.sv @@
// Stable bottom-up merge sort over two ping-pong edge banks.
module pgmst_sort #(
  parameter int EDGE_DEPTH = 2080,
  parameter int EDGE_W = 48,
  localparam int EA = $clog2(EDGE_DEPTH),
  localparam int EW = $clog2(EDGE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              gen_we,
  input  logic [EA-1:0]     gen_addr,
  input  logic [EDGE_W-1:0] gen_data,
  input  logic              start,
  input  logic [EW-1:0]     ne,
  output logic              busy,
  input  logic [EA-1:0]     rd_addr,
  output logic [EDGE_W-1:0] rd_data
);
  import pgmst_pkg::*;

  localparam int LW = EW + 2;

  sort_state_t sstate, sstate_next;
  logic src;
  logic [LW-1:0] ne_q, width, lo, mid, hi, ii, jj, kk;
  logic [LW-1:0] lo_w, lo_2w, mid_c, hi_c;

  logic [EDGE_W-1:0] bank_a [EDGE_DEPTH];
  logic [EDGE_W-1:0] bank_b [EDGE_DEPTH];
  logic [EDGE_W-1:0] qa_a, qb_a, qa_b, qb_b, a_dat, b_dat, wr_data;
  logic [EA-1:0] ra, rb, wa;
  logic wr_en, we_a, we_b, take_j;

  assign busy = sstate != SS_IDLE;
  assign ra = busy ? ii[EA-1:0] : rd_addr;
  assign rb = jj[EA-1:0];
  assign a_dat = src ? qa_b : qa_a;
  assign b_dat = src ? qb_b : qb_a;
  assign rd_data = a_dat;

  // stable: take the right run only when strictly lighter
  assign take_j = (jj < hi) &&
                  ((ii >= mid) || (b_dat[EDGE_W-1 -: W_W] < a_dat[EDGE_W-1 -: W_W]));
  assign wr_en = sstate == SS_CMP;
  assign wr_data = take_j ? b_dat : a_dat;
  assign we_a = gen_we | (wr_en & src);
  assign we_b = wr_en & ~src;
  assign wa = gen_we ? gen_addr : kk[EA-1:0];

  assign lo_w = lo + width;
  assign lo_2w = lo + (width << 1);
  assign mid_c = (lo_w < ne_q) ? lo_w : ne_q;
  assign hi_c = (lo_2w < ne_q) ? lo_2w : ne_q;

  always_ff @(posedge clk) begin
    if (we_a) begin
      bank_a[wa] <= gen_we ? gen_data : wr_data;
    end
    if (we_b) begin
      bank_b[kk[EA-1:0]] <= wr_data;
    end
    qa_a <= bank_a[ra];
    qb_a <= bank_a[rb];
    qa_b <= bank_b[ra];
    qb_b <= bank_b[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sstate <= SS_IDLE;
    end else begin
      sstate <= sstate_next;
    end
  end

  always_comb begin
    sstate_next = sstate;
    unique case (sstate)
      SS_IDLE: if (start) sstate_next = SS_PASS;
      SS_PASS: sstate_next = (width < ne_q) ? SS_BLK : SS_IDLE;
      SS_BLK:  sstate_next = (lo < ne_q) ? SS_RD : SS_PASS;
      SS_RD:   sstate_next = SS_CMP;
      SS_CMP:  sstate_next = (kk + 1'b1 == hi) ? SS_BLK : SS_RD;
      default: sstate_next = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src <= 1'b0;
    end else begin
      case (sstate)
        SS_IDLE: begin
          if (start) begin
            ne_q <= LW'(ne);
            width <= LW'(1);
            src <= 1'b0;
          end
        end
        SS_PASS: lo <= '0;
        SS_BLK: begin
          if (lo < ne_q) begin
            mid <= mid_c;
            hi <= hi_c;
            ii <= lo;
            jj <= mid_c;
            kk <= lo;
          end else begin
            src <= ~src;
            width <= width << 1;
          end
        end
        SS_CMP: begin
          kk <= kk + 1'b1;
          if (take_j) jj <= jj + 1'b1;
          else ii <= ii + 1'b1;
          if (kk + 1'b1 == hi) lo <= lo_2w;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/pgmst_uf.sv @@
// Component label table: find reads two labels, merge relabels by a sweep.
module pgmst_uf #(
  parameter int MAX_CITIES = 64,
  localparam int NW = $clog2(MAX_CITIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  pgmst_pkg::uf_op_t op,
  input  logic [NW-1:0]     a,
  input  logic [NW-1:0]     b,
  input  logic [NW-1:0]     n,
  output logic              busy,
  output logic [NW-1:0]     la,
  output logic [NW-1:0]     lb
);
  import pgmst_pkg::*;

  uf_state_t ustate, ustate_next;
  logic [NW-1:0] comp [MAX_CITIES + 1];
  logic [NW-1:0] qa, qb, ra, wa, wd, from_q, to_q, n_q, paddr;
  logic [NW:0] cnt;
  logic pv, we;

  assign busy = ustate != U_IDLE;
  assign ra = (ustate == U_MERGE) ? cnt[NW-1:0] : a;
  assign we = (ustate == U_INIT) || ((ustate == U_MERGE) && pv && (qa == from_q));
  assign wa = (ustate == U_INIT) ? cnt[NW-1:0] : paddr;
  assign wd = (ustate == U_INIT) ? cnt[NW-1:0] : to_q;

  always_ff @(posedge clk) begin
    if (we) begin
      comp[wa] <= wd;
    end
    qa <= comp[ra];
    qb <= comp[b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
    end else begin
      ustate <= ustate_next;
    end
  end

  always_comb begin
    ustate_next = ustate;
    unique case (ustate)
      U_IDLE: begin
        unique case (op)
          UF_INIT:  ustate_next = U_INIT;
          UF_FIND:  ustate_next = U_FIND;
          UF_MERGE: ustate_next = U_MERGE;
          default:  ustate_next = U_IDLE;
        endcase
      end
      U_INIT:  if (cnt[NW-1:0] == n_q) ustate_next = U_IDLE;
      U_FIND:  ustate_next = U_IDLE;
      U_MERGE: if (pv && paddr == n_q) ustate_next = U_IDLE;
      default: ustate_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      case (ustate)
        U_IDLE: begin
          cnt <= '0;
          pv <= 1'b0;
          if (op == UF_INIT) n_q <= n;
          if (op == UF_MERGE) begin
            from_q <= a;
            to_q <= b;
            n_q <= n;
          end
        end
        U_INIT: cnt <= cnt + 1'b1;
        U_FIND: begin
          la <= qa;
          lb <= qb;
        end
        U_MERGE: begin
          // read one entry ahead of the write-back
          if (cnt <= {1'b0, n_q}) begin
            pv <= 1'b1;
            paddr <= cnt[NW-1:0];
            cnt <= cnt + 1'b1;
          end else begin
            pv <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/power_grid_min_spanning_tree.sv @@
// Loading: the last city starts a solve that builds station and pair edges,
//   merge sorts them, scans them in weight order and then emits the picks.
// Throughput: one city per cycle while loading; busy stays high through solve.
// Each result is strobed for one cycle; there is no output stall.
// Reset clears control state only; the label table is swept at each solve.
module power_grid_min_spanning_tree #(
  parameter int MAX_CITIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pgmst_pkg::item_t   item,
  output logic               valid,
  output pgmst_pkg::result_t result
);
  import pgmst_pkg::*;

  localparam int NW = $clog2(MAX_CITIES + 1);
  localparam int CA = $clog2(MAX_CITIES);
  localparam int EDGE_DEPTH = MAX_CITIES + (MAX_CITIES * (MAX_CITIES - 1)) / 2;
  localparam int EA = $clog2(EDGE_DEPTH);
  localparam int EW = $clog2(EDGE_DEPTH + 1);
  localparam int EDGE_W = W_W + 2 * NW;

  state_t state, state_next;
  logic [NW-1:0] count, gi, gj, acnt, nst, nw, oi;
  logic ovf;
  logic [TOT_W-1:0] cost;
  logic [EW-1:0] e, idx;
  city_rec_t ci, city_q;
  city_rec_t city_mem [MAX_CITIES];
  logic [CA-1:0] city_ra;
  logic [16:0] rate_q, dist_q;
  logic [15:0] dx, dy;
  logic [W_W-1:0] prod;
  logic [EDGE_W-1:0] edge_q, gen_data, rd_data;
  logic gen_we, sort_start, sort_busy;
  logic [2*NW-1:0] acc_mem [MAX_CITIES];
  logic [2*NW-1:0] acc_q, acc_wd;
  logic [CA-1:0] acc_ra, acc_wa;
  logic acc_we, accept;
  uf_op_t uf_op;
  logic [NW-1:0] uf_a, uf_b, la, lb;
  logic uf_busy;
  logic [NW-1:0] e_u, e_v;

  assign busy = state != S_LOAD;

  always_ff @(posedge clk) begin
    if (!busy && start && count < NW'(MAX_CITIES)) begin
      city_mem[count[CA-1:0]] <= '{x: item.city_x, y: item.city_y,
                                  cost: item.station_cost, rate: item.wire_rate};
    end
    city_q <= city_mem[city_ra];
  end

  always_comb begin
    case (state)
      S_PJ_RD: city_ra = CA'(gj - 1'b1);
      default: city_ra = CA'(gi - 1'b1);
    endcase
  end

  assign dx = (ci.x > city_q.x) ? ci.x - city_q.x : city_q.x - ci.x;
  assign dy = (ci.y > city_q.y) ? ci.y - city_q.y : city_q.y - ci.y;
  assign prod = rate_q * dist_q;

  assign gen_we = (state == S_ST_WR) || (state == S_PJ_MUL);
  assign gen_data = (state == S_ST_WR) ? {W_W'(city_q.cost), {NW{1'b0}}, gi}
                                       : {prod, gi, gj};
  assign sort_start = state == S_SORT_GO;

  pgmst_sort #(.EDGE_DEPTH(EDGE_DEPTH), .EDGE_W(EDGE_W)) u_sort (
    .clk(clk), .rst(rst),
    .gen_we(gen_we), .gen_addr(e[EA-1:0]), .gen_data(gen_data),
    .start(sort_start), .ne(e), .busy(sort_busy),
    .rd_addr(idx[EA-1:0]), .rd_data(rd_data)
  );

  assign e_u = edge_q[2*NW-1:NW];
  assign e_v = edge_q[NW-1:0];
  assign accept = (state == S_SC_WAIT) && !uf_busy && (la != lb);

  always_comb begin
    uf_op = UF_NOP;
    uf_a = rd_data[2*NW-1:NW];
    uf_b = rd_data[NW-1:0];
    case (state)
      S_INIT: uf_op = UF_INIT;
      S_SC_FIND: uf_op = UF_FIND;
      S_SC_WAIT: begin
        uf_a = la;
        uf_b = lb;
        if (accept) uf_op = UF_MERGE;
      end
      default: ;
    endcase
  end

  pgmst_uf #(.MAX_CITIES(MAX_CITIES)) u_uf (
    .clk(clk), .rst(rst), .op(uf_op), .a(uf_a), .b(uf_b), .n(count),
    .busy(uf_busy), .la(la), .lb(lb)
  );

  // stations fill from the front, wires from the back
  assign acc_we = accept;
  assign acc_wa = (e_u == '0) ? nst[CA-1:0] : CA'(count - 1'b1 - nw);
  assign acc_wd = (e_u == '0) ? {e_v, {NW{1'b0}}} : {e_u, e_v};
  assign acc_ra = (oi < nst) ? oi[CA-1:0] : CA'(count - 1'b1 + nst - oi);

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:    if (start && item.last_city) state_next = S_INIT;
      S_INIT:    state_next = S_IWAIT;
      S_IWAIT:   if (!uf_busy) state_next = S_ST_RD;
      S_ST_RD:   state_next = S_ST_WR;
      S_ST_WR: begin
        if (gi == count) state_next = (count == NW'(1)) ? S_SORT_GO : S_PI_RD;
        else state_next = S_ST_RD;
      end
      S_PI_RD:   state_next = S_PI_LAT;
      S_PI_LAT:  state_next = S_PJ_RD;
      S_PJ_RD:   state_next = S_PJ_DIFF;
      S_PJ_DIFF: state_next = S_PJ_MUL;
      S_PJ_MUL: begin
        if (gj != count) state_next = S_PJ_RD;
        else if (gi + 1'b1 == count) state_next = S_SORT_GO;
        else state_next = S_PI_RD;
      end
      S_SORT_GO: state_next = S_SORT;
      S_SORT:    if (!sort_busy) state_next = S_SC_RD;
      S_SC_RD:   state_next = S_SC_FIND;
      S_SC_FIND: state_next = S_SC_WAIT;
      S_SC_WAIT: begin
        if (!uf_busy) begin
          if (la != lb) state_next = S_SC_MWAIT;
          else if (idx + 1'b1 == e) state_next = S_OUT_RD;
          else state_next = S_SC_RD;
        end
      end
      S_SC_MWAIT: begin
        if (!uf_busy) begin
          if (acnt == count || idx + 1'b1 == e) state_next = S_OUT_RD;
          else state_next = S_SC_RD;
        end
      end
      S_OUT_RD:   state_next = S_OUT_EMIT;
      S_OUT_EMIT: state_next = (oi + 1'b1 == count) ? S_LOAD : S_OUT_RD;
      default:    state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf <= 1'b0;
      cost <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (start) begin
            if (count < NW'(MAX_CITIES)) count <= count + 1'b1;
            else ovf <= 1'b1;
          end
        end
        S_INIT: begin
          gi <= NW'(1);
          e <= '0;
          idx <= '0;
          cost <= '0;
          acnt <= '0;
          nst <= '0;
          nw <= '0;
        end
        S_ST_WR: begin
          e <= e + 1'b1;
          gi <= (gi == count) ? NW'(1) : gi + 1'b1;
        end
        S_PI_LAT: begin
          ci <= city_q;
          gj <= gi + 1'b1;
        end
        S_PJ_DIFF: begin
          rate_q <= {1'b0, ci.rate} + {1'b0, city_q.rate};
          dist_q <= {1'b0, dx} + {1'b0, dy};
        end
        S_PJ_MUL: begin
          e <= e + 1'b1;
          if (gj != count) gj <= gj + 1'b1;
          else gi <= gi + 1'b1;
        end
        S_SC_FIND: edge_q <= rd_data;
        S_SC_WAIT: begin
          if (!uf_busy) begin
            if (la != lb) begin
              cost <= cost + TOT_W'(edge_q[EDGE_W-1 -: W_W]);
              acnt <= acnt + 1'b1;
              if (e_u == '0) nst <= nst + 1'b1;
              else nw <= nw + 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          oi <= '0;
        end
        S_SC_MWAIT: if (!uf_busy) idx <= idx + 1'b1;
        S_OUT_EMIT: begin
          oi <= oi + 1'b1;
          if (oi + 1'b1 == count) begin
            count <= '0;
            ovf <= 1'b0;
            cost <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign valid = state == S_OUT_EMIT;
  assign result.kind = (oi < nst) ? KIND_STATION : KIND_WIRE;
  assign result.city_a = IDX_W'(acc_q[2*NW-1:NW]);
  assign result.city_b = IDX_W'(acc_q[NW-1:0]);
  assign result.total_cost = cost;
  assign result.last = oi + 1'b1 == count;
  assign result.overflowed = ovf;

  a_valid_busy: assert property (@(posedge clk) disable iff (rst) valid |-> busy)
    else $error("result strobe outside a solve");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && result.last |=> !busy)
    else $error("block still busy after final result");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MAX_CITIES))
    else $error("city count beyond capacity");
  a_station_b: assert property (@(posedge clk) disable iff (rst)
    valid && result.kind == KIND_STATION |-> result.city_b == '0)
    else $error("station result carries a second city");

endmodule

@@ test/tb_power_grid_min_spanning_tree.sv @@
`timescale 1ns / 100ps

module tb_power_grid_min_spanning_tree;
  import pgmst_pkg::*;

  localparam int NCAP = 64;
  localparam int WATCH_LIMIT = 4000000;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    valid;
  result_t result;
  logic    busy_q;

  power_grid_min_spanning_tree #(.MAX_CITIES(NCAP)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .valid(valid), .result(result)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor state
  city_rec_t cities[NCAP];
  int        n_cities;
  bit        dropped;

  item_t     pending_items[$];
  result_t   expected_picks[$];
  int        errors;
  int        sender_idle_pct;
  int        quiet_cycles;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int find_root(ref int par[NCAP+1], input int node);
    int r;
    int nx;
    r = node;
    while (par[r] != r) r = par[r];
    while (par[node] != r) begin
      nx = par[node];
      par[node] = r;
      node = nx;
    end
    return r;
  endfunction

  // Kruskal over station edges + pair edges; insertion order kept by stable sort
  task automatic solve_grid();
    int eu[$], ev[$];
    logic [W_W-1:0] ew[$];
    int order[$];
    int par[NCAP+1];
    int st_a[$], wa[$], wb[$];
    logic [TOT_W-1:0] total;
    logic [16:0] rate;
    logic [16:0] span_len;
    int fu, fv, k, e, t;
    result_t r;
    for (int i = 0; i <= n_cities; i++) par[i] = i;
    for (int i = 1; i <= n_cities; i++) begin
      eu = {eu, 0}; ev = {ev, i};
      ew = {ew, W_W'(cities[i-1].cost)};
    end
    for (int i = 1; i <= n_cities; i++)
      for (int j = i + 1; j <= n_cities; j++) begin
        rate = 17'(cities[i-1].rate) + 17'(cities[j-1].rate);
        span_len = 17'((cities[i-1].x > cities[j-1].x) ? cities[i-1].x - cities[j-1].x
                                                       : cities[j-1].x - cities[i-1].x)
                 + 17'((cities[i-1].y > cities[j-1].y) ? cities[i-1].y - cities[j-1].y
                                                       : cities[j-1].y - cities[i-1].y);
        eu = {eu, i}; ev = {ev, j};
        ew = {ew, W_W'(rate) * W_W'(span_len)};
      end
    for (int i = 0; i < eu.size(); i++) order = {order, i};
    // stable insertion sort by weight
    for (int i = 1; i < order.size(); i++) begin
      t = order[i];
      k = i - 1;
      while (k >= 0 && ew[order[k]] > ew[t]) begin
        order[k+1] = order[k];
        k--;
      end
      order[k+1] = t;
    end
    total = '0;
    foreach (order[i]) begin
      e = order[i];
      fu = find_root(par, eu[e]);
      fv = find_root(par, ev[e]);
      if (fu != fv) begin
        par[fu] = fv;
        total += TOT_W'(ew[e]);
        if (eu[e] == 0) st_a = {st_a, ev[e]};
        else begin
          wa = {wa, eu[e]}; wb = {wb, ev[e]};
        end
      end
    end
    k = st_a.size() + wa.size();
    for (int i = 0; i < k; i++) begin
      r.kind = (i < st_a.size()) ? KIND_STATION : KIND_WIRE;
      r.city_a = IDX_W'((i < st_a.size()) ? st_a[i] : wa[i - st_a.size()]);
      r.city_b = IDX_W'((i < st_a.size()) ? 0 : wb[i - st_a.size()]);
      r.total_cost = total;
      r.last = (i + 1 == k);
      r.overflowed = dropped;
      expected_picks = {expected_picks, r};
    end
    n_cities = 0;
    dropped = 1'b0;
  endtask

  task automatic load_city(input item_t it);
    if (n_cities < NCAP) begin
      cities[n_cities] = '{x: it.city_x, y: it.city_y, cost: it.station_cost,
                           rate: it.wire_rate};
      n_cities++;
    end else begin
      dropped = 1'b1;
    end
    if (it.last_city) solve_grid();
  endtask

  function automatic item_t rand_city(input bit fin, input int mode);
    item_t it;
    it.city_x = 16'($urandom);
    it.city_y = 16'($urandom);
    it.station_cost = $urandom;
    it.wire_rate = 16'($urandom);
    if (mode == 1) begin
      // small values so stations and wires compete and ties appear
      it.city_x = 16'($urandom_range(0, 7));
      it.city_y = 16'($urandom_range(0, 7));
      it.station_cost = $urandom_range(0, 40);
      it.wire_rate = 16'($urandom_range(0, 3));
    end
    it.last_city = fin;
    return it;
  endfunction

  task automatic add_set(input int n, input int mode);
    for (int i = 0; i < n; i++) pending_items = {pending_items, rand_city(i == n - 1, mode)};
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_q) begin
      // previous transfer happened at the last rising edge
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst) begin
      if ((start && !busy) || valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (start && !busy) begin
        load_city(item);
      end
      if (valid) begin
        if (expected_picks.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          result_t ex;
          ex = expected_picks.pop_front();
          if (result.kind !== ex.kind)
            report_mismatch($sformatf("kind %0b exp %0b", result.kind, ex.kind));
          if (result.city_a !== ex.city_a)
            report_mismatch($sformatf("city_a %0d exp %0d", result.city_a, ex.city_a));
          if (result.city_b !== ex.city_b)
            report_mismatch($sformatf("city_b %0d exp %0d", result.city_b, ex.city_b));
          if (result.total_cost !== ex.total_cost)
            report_mismatch($sformatf("total %0d exp %0d", result.total_cost,
                                      ex.total_cost));
          if (result.last !== ex.last)
            report_mismatch($sformatf("last %0b exp %0b", result.last, ex.last));
          if (result.overflowed !== ex.overflowed)
            report_mismatch($sformatf("overflowed %0b exp %0b", result.overflowed,
                                      ex.overflowed));
        end
      end
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic run_phase(input int idle_pct);
    sender_idle_pct = idle_pct;
    wait (pending_items.size() == 0);
  endtask

  initial begin
    item_t it;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    busy_q = 1'b0;
    errors = 0;
    n_cities = 0;
    dropped = 1'b0;
    quiet_cycles = 0;
    sender_idle_pct = 37;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single city, all-max fields, all-zero fields, ties
    it = '1;
    pending_items = {pending_items, it};
    it = '0; pending_items = {pending_items, it};
    it.last_city = 1'b1; pending_items = {pending_items, it};
    it = '1; it.last_city = 1'b0; pending_items = {pending_items, it};
    it = '0; it.station_cost = '1; it.last_city = 1'b1; pending_items = {pending_items, it};
    // equal stations, cheap wires
    for (int i = 0; i < 4; i++) begin
      it = '0; it.city_x = 16'(i); it.station_cost = 32'd10; it.wire_rate = 16'd1;
      it.last_city = (i == 3);
      pending_items = {pending_items, it};
    end
    // expensive wires, cheap stations
    for (int i = 0; i < 3; i++) begin
      it = '1; it.city_x = 16'(i * 30000); it.station_cost = 32'(i); it.last_city = (i == 2);
      pending_items = {pending_items, it};
    end
    add_set(5, 1);
    add_set(3, 0);
    run_phase(37);

    // random sets, mostly small, a full set and an overflowing one
    add_set(NCAP + 3, 1);
    for (int s = 0; s < 10; s++) add_set($urandom_range(2, 8), $urandom_range(0, 1));
    run_phase(59);
    add_set(NCAP, 0);
    for (int s = 0; s < 10; s++) add_set($urandom_range(1, 8), $urandom_range(0, 1));
    run_phase(0);
    for (int s = 0; s < 12; s++) add_set($urandom_range(1, 6), 1);
    run_phase(0);

    wait (!start);
    wait (expected_picks.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pgmst_pkg.sv
src/pgmst_sort.sv
src/pgmst_uf.sv
src/power_grid_min_spanning_tree.sv
test/tb_power_grid_min_spanning_tree.sv
